// File: rtl/dual_band_fir_mixer_defines.svh
// ---------------------------------------------------------------------------
// dual_band_fir_mixer_defines.svh
// Assertion macros used by the mixer top level.
// ---------------------------------------------------------------------------
`ifndef DUAL_BAND_FIR_MIXER_DEFINES_SVH
`define DUAL_BAND_FIR_MIXER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define DBFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbfm: implication check failed");

// Next-cycle implication, held off during reset
`define DBFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbfm: next-cycle check failed");

`endif

// File: rtl/dbfm_pkg.sv
// ---------------------------------------------------------------------------
// dbfm_pkg
// Types, widths and coefficient tables for the dual-band FIR mixer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbfm_pkg;

    localparam int TAP_COUNT = 7;
    localparam int ADDR_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int ACC_W     = 32;                  // 7 taps of Q2.13 x Q1.15 fit
    localparam int PROD_W    = ACC_W + GAIN_W + 1;  // signed acc x unsigned gain
    localparam int MIX_W     = PROD_W + 1;
    localparam int SHIFT     = 32;                  // halve and return to Q.13
    localparam int Q_W       = MIX_W - SHIFT;
    localparam int OUT_SUM_W = Q_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd32768;
    localparam logic signed [MIX_W-1:0]    ROUND_HALF = MIX_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [OUT_SUM_W-1:0] OFFSET_Q13 = OUT_SUM_W'(13517);
    localparam logic signed [OUT_SUM_W-1:0] SAT_MAX    = OUT_SUM_W'(32767);
    localparam logic signed [OUT_SUM_W-1:0] SAT_MIN    = -OUT_SUM_W'(32768);
    localparam logic [ADDR_W-1:0]          LAST_ADDR  = ADDR_W'(TAP_COUNT - 1);

    // Q1.15 coefficient tables, index 0 meets the newest sample
    localparam logic signed [COEF_W-1:0] LP_TAPS [TAP_COUNT] = '{
        16'sd2569, 16'sd5803, 16'sd7214, 16'sd9041, 16'sd7214, 16'sd5803, 16'sd2569
    };
    localparam logic signed [COEF_W-1:0] HP_TAPS [TAP_COUNT] = '{
        -16'sd2902, 16'sd6554, -16'sd4355, 16'sd25413, -16'sd4355, -16'sd6554,
        -16'sd2902
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_GAIN  = 1'b0,
        CFG_HIGH_GAIN = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_FLUSH,
        S_GAIN,
        S_MIX
    } t_state;

    typedef struct packed {
        logic                       wr_en;
        logic [ADDR_W-1:0]          wr_addr;
        logic signed [SAMPLE_W-1:0] wr_data;
        logic                       rd_en;
        logic [ADDR_W-1:0]          rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic busy;
        logic mixing;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/dbfm_delay_mem.sv
// ---------------------------------------------------------------------------
// dbfm_delay_mem
// Delay-line store: one write and one registered read per cycle. Entries
// not yet written since reset read as zero through per-entry valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbfm_delay_mem (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  dbfm_pkg::t_mem_req                    i_req,
    output logic signed [dbfm_pkg::SAMPLE_W-1:0] o_rd_data
);

    logic signed [dbfm_pkg::SAMPLE_W-1:0] r_mem [dbfm_pkg::TAP_COUNT];
    logic [dbfm_pkg::TAP_COUNT-1:0]       r_valid;
    logic signed [dbfm_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                                 r_rd_valid;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Mark written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: rtl/dbfm_datapath.sv
// ---------------------------------------------------------------------------
// dbfm_datapath
// Sequencer and shared multiply-accumulate: walks the delay line newest
// first, accumulates both bands, applies gains, rounds, offsets, saturates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbfm_datapath (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire signed [dbfm_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire [dbfm_pkg::GAIN_W-1:0]            i_low_gain,
    input  wire [dbfm_pkg::GAIN_W-1:0]            i_high_gain,
    output dbfm_pkg::t_mem_req                    o_mem_req,
    input  wire signed [dbfm_pkg::SAMPLE_W-1:0]   i_rd_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [dbfm_pkg::SAMPLE_W-1:0] o_sample,
    output dbfm_pkg::t_dp_status                  o_status
);

    dbfm_pkg::t_state r_state, n_state;

    logic [dbfm_pkg::ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [dbfm_pkg::ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [dbfm_pkg::ADDR_W-1:0] r_tap, n_tap;
    logic [dbfm_pkg::ADDR_W-1:0] r_tap_d;
    logic                        r_acc_en;

    logic signed [dbfm_pkg::ACC_W-1:0]    r_acc_lo, r_acc_hi;
    logic signed [dbfm_pkg::PROD_W-1:0]   r_prod_lo, r_prod_hi;
    logic signed [dbfm_pkg::SAMPLE_W-1:0] r_out;
    logic                                 r_out_vld, n_out_vld;

    logic                                  w_accept;
    logic                                  w_load;
    logic                                  w_clear;
    logic signed [dbfm_pkg::ACC_W-1:0]     w_mul_lo, w_mul_hi;
    logic signed [dbfm_pkg::MIX_W-1:0]     w_mix;
    logic signed [dbfm_pkg::Q_W-1:0]       w_q13;
    logic signed [dbfm_pkg::OUT_SUM_W-1:0] w_biased;
    logic signed [dbfm_pkg::SAMPLE_W-1:0]  w_sat;

    assign o_in_ready = (r_state == dbfm_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_clear    = w_accept;

    // Memory requests: write on accept, walk reads during the tap phase
    always_comb begin
        o_mem_req.wr_en   = w_accept;
        o_mem_req.wr_addr = r_wr_ptr;
        o_mem_req.wr_data = i_sample;
        o_mem_req.rd_en   = (r_state == dbfm_pkg::S_TAPS);
        o_mem_req.rd_addr = r_rd_addr;
    end

    // Next state and sequencing
    always_comb begin
        n_state   = r_state;
        n_wr_ptr  = r_wr_ptr;
        n_rd_addr = r_rd_addr;
        n_tap     = r_tap;
        w_load    = 1'b0;
        unique case (r_state)
            dbfm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_rd_addr = r_wr_ptr;
                    n_wr_ptr  = (r_wr_ptr == dbfm_pkg::LAST_ADDR) ? '0 : r_wr_ptr + 1'b1;
                    n_tap     = '0;
                    n_state   = dbfm_pkg::S_TAPS;
                end
            end
            dbfm_pkg::S_TAPS: begin
                n_rd_addr = (r_rd_addr == '0) ? dbfm_pkg::LAST_ADDR : r_rd_addr - 1'b1;
                n_tap     = r_tap + 1'b1;
                if (r_tap == dbfm_pkg::LAST_ADDR) begin
                    n_state = dbfm_pkg::S_FLUSH;
                end
            end
            dbfm_pkg::S_FLUSH: begin
                n_state = dbfm_pkg::S_GAIN;
            end
            dbfm_pkg::S_GAIN: begin
                n_state = dbfm_pkg::S_MIX;
            end
            dbfm_pkg::S_MIX: begin
                if (!r_out_vld || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = dbfm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dbfm_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbfm_pkg::S_IDLE;
            r_wr_ptr  <= '0;
            r_rd_addr <= '0;
            r_tap     <= '0;
            r_tap_d   <= '0;
            r_acc_en  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_addr <= n_rd_addr;
            r_tap     <= n_tap;
            r_tap_d   <= r_tap;
            r_acc_en  <= (r_state == dbfm_pkg::S_TAPS);
            r_out_vld <= n_out_vld;
        end
    end

    // Output beat register
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Tap products for both bands
    assign w_mul_lo = i_rd_data * dbfm_pkg::LP_TAPS[r_tap_d];
    assign w_mul_hi = i_rd_data * dbfm_pkg::HP_TAPS[r_tap_d];

    // Accumulate, one delay-line entry per cycle
    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_acc_lo <= '0;
            r_acc_hi <= '0;
        end else if (r_acc_en) begin
            r_acc_lo <= r_acc_lo + w_mul_lo;
            r_acc_hi <= r_acc_hi + w_mul_hi;
        end
    end

    // Apply band gains
    always_ff @(posedge i_clk) begin
        if (r_state == dbfm_pkg::S_GAIN) begin
            r_prod_lo <= r_acc_lo * $signed({1'b0, i_low_gain});
            r_prod_hi <= r_acc_hi * $signed({1'b0, i_high_gain});
        end
    end

    // Sum, round half up on the shift, add offset, saturate
    always_comb begin
        w_mix    = dbfm_pkg::MIX_W'(r_prod_lo) + dbfm_pkg::MIX_W'(r_prod_hi)
                 + dbfm_pkg::ROUND_HALF;
        w_q13    = w_mix[dbfm_pkg::MIX_W-1:dbfm_pkg::SHIFT];
        w_biased = dbfm_pkg::OUT_SUM_W'(w_q13) + dbfm_pkg::OFFSET_Q13;
        if (w_biased > dbfm_pkg::SAT_MAX) begin
            w_sat = dbfm_pkg::SAMPLE_W'(dbfm_pkg::SAT_MAX);
        end else if (w_biased < dbfm_pkg::SAT_MIN) begin
            w_sat = dbfm_pkg::SAMPLE_W'(dbfm_pkg::SAT_MIN);
        end else begin
            w_sat = w_biased[dbfm_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_sat;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sample        = r_out;
    assign o_status.busy   = (r_state != dbfm_pkg::S_IDLE);
    assign o_status.mixing = (r_state == dbfm_pkg::S_MIX);

endmodule

`default_nettype wire

// File: rtl/dual_band_fir_mixer.sv
// An input beat is taken only in idle. The sample then passes through 7
// registered delay-line reads in the shared multiply-accumulate and the
// flush, gain and mix states; the result beat is registered as mix returns
// to idle. A finished sample holds in mix, and the input waits, while the previous
// result beat is still unaccepted. Reset (synchronous, active low) zeroes
// the delay line and sets both gains to 0.5.
// ---------------------------------------------------------------------------
// dual_band_fir_mixer
// Two-band 7-tap FIR mixer with per-band gain, offset and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_band_fir_mixer_defines.svh"

module dual_band_fir_mixer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // config write port
    input  wire                              i_cfg_we,
    input  wire [dbfm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [dbfm_pkg::GAIN_W-1:0]       i_cfg_data,
    // input stream
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire signed [15:0]                i_s_axis_tdata,   // [15:0] sample_in
    // output stream
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic signed [15:0]               o_m_axis_tdata    // [15:0] sample_out
);

    logic [dbfm_pkg::GAIN_W-1:0] r_low_gain;
    logic [dbfm_pkg::GAIN_W-1:0] r_high_gain;

    dbfm_pkg::t_mem_req                    w_mem_req;
    dbfm_pkg::t_dp_status                  w_status;
    logic signed [dbfm_pkg::SAMPLE_W-1:0]  w_rd_data;

    // Gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_gain  <= dbfm_pkg::GAIN_RESET;
            r_high_gain <= dbfm_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (dbfm_pkg::t_cfg_idx'(i_cfg_idx))
                dbfm_pkg::CFG_LOW_GAIN:  r_low_gain  <= i_cfg_data;
                dbfm_pkg::CFG_HIGH_GAIN: r_high_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dbfm_delay_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    dbfm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata),
        .i_low_gain  (r_low_gain),
        .i_high_gain (r_high_gain),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_sample    (o_m_axis_tdata),
        .o_status    (w_status)
    );

    // Checks
    `DBFM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, w_status.busy && !o_s_axis_tready)
    `DBFM_ASSERT_IMP(a_out_from_mix, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(w_status.mixing))
    `DBFM_ASSERT_IMP(a_read_only_busy, i_clk, i_rst_n, w_mem_req.rd_en, !o_s_axis_tready && !w_mem_req.wr_en)

endmodule

`default_nettype wire

// File: dv/dbfm_mix_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbfm_mix_checker
// Watches the config port and both stream channels of the dual-band FIR
// mixer. Keeps its own delay line and gains, predicts one output sample per
// accepted input beat and compares it with each accepted output beat.
// ---------------------------------------------------------------------------
module dbfm_mix_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dbfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [15:0]                    i_s_tdata,   // [15:0] sample_in
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [15:0]                    i_m_tdata,   // [15:0] sample_out
    output int                             o_pending,
    output int                             o_err_count
);

    localparam int         NTAPS      = 7;
    localparam longint     MID_VOLTS  = 13517;  // 1.65 V in Q2.13
    localparam longint     OUT_MAX    = 32767;
    localparam longint     OUT_MIN    = -32768;
    localparam int         LOW_COEF  [NTAPS] = '{2569, 5803, 7214, 9041, 7214, 5803, 2569};
    localparam int         HIGH_COEF [NTAPS] = '{-2902, 6554, -4355, 25413, -4355, -6554,
                                                 -2902};

    logic signed [15:0] window [NTAPS];   // entry 0 is the newest sample
    logic [15:0]        low_gain;
    logic [15:0]        high_gain;
    logic [15:0]        mixed_q [$];
    int                 mismatches = 0;

    assign o_err_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("chk: %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // Run both filters over the current window, scale, halve, offset, clip
    function automatic logic [15:0] mixed_sample();
        longint low_acc;
        longint high_acc;
        longint mix;
        longint q13;
        int     k;
        low_acc  = 0;
        high_acc = 0;
        for (k = 0; k < NTAPS; k++) begin
            low_acc  += longint'(window[k]) * LOW_COEF[k];
            high_acc += longint'(window[k]) * HIGH_COEF[k];
        end
        mix = low_acc * longint'(low_gain) + high_acc * longint'(high_gain);
        // round half up while dropping 32 fraction bits
        q13 = (mix + (longint'(1) <<< 31)) >>> 32;
        q13 += MID_VOLTS;
        if (q13 > OUT_MAX) q13 = OUT_MAX;
        if (q13 < OUT_MIN) q13 = OUT_MIN;
        return q13[15:0];
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] want;
        int          k;
        if (!i_rst_n) begin
            for (k = 0; k < NTAPS; k++) window[k] = '0;
            low_gain  = dbfm_pkg::GAIN_RESET;
            high_gain = dbfm_pkg::GAIN_RESET;
            mixed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dbfm_pkg::CFG_LOW_GAIN:  low_gain  = i_cfg_data;
                    dbfm_pkg::CFG_HIGH_GAIN: high_gain = i_cfg_data;
                    default: ;
                endcase
            end
            // compare each output beat with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (mixed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output beat 0x%04h", i_m_tdata));
                end else begin
                    want = mixed_q.pop_front();
                    if (i_m_tdata !== want)
                        report_mismatch($sformatf("sample_out 0x%04h, expected 0x%04h",
                                                  i_m_tdata, want));
                end
            end
            // shift the new sample in and predict its output
            if (i_s_tvalid && i_s_tready) begin
                for (k = NTAPS - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = i_s_tdata;
                mixed_q.push_back(mixed_sample());
            end
        end
        o_pending <= mixed_q.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dual-band FIR mixer. A directed run covers
// the sample extremes, reset gains, positive clipping and the most negative
// window, then random samples run under several gain settings and idle and
// stall patterns, with one long output hold-off. The checker predicts and
// compares.
// ---------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel
    localparam int HOLDOFF_LEN  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 100;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_we        = 1'b0;
    logic [dbfm_pkg::CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [dbfm_pkg::GAIN_W-1:0]    i_cfg_data      = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic signed [15:0]             i_s_axis_tdata  = '0;   // [15:0] sample_in
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic signed [15:0]             o_m_axis_tdata;         // [15:0] sample_out

    int   pending;
    int   err_count;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    bit   hold_start = 1'b0;
    int   hold_left  = 0;
    int   quiet_cycles = 0;

    dual_band_fir_mixer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    dbfm_mix_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .o_pending   (pending),
        .o_err_count (err_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLDOFF_LEN;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abort when no beat moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Offer one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid and hold until every predicted sample has come out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gain(input dbfm_pkg::t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly full-range samples, with rails and small values mixed in
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'h7fff;
            1:       v = 16'h8000;
            2:       v = 16'($signed($urandom_range(512)) - 256);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++) send_sample(pick_sample());
    endtask

    initial begin
        // window that drives every tap against the sign of low+high coefficient
        logic [15:0] neg_window [7];
        int          k;
        neg_window = '{16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                       16'h7fff};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset gains, rails and alternating bit patterns
        send_sample(16'h0000);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        wait_drained();

        // Full gain: clip high, then the most negative window
        set_gain(dbfm_pkg::CFG_LOW_GAIN, 16'hffff);
        set_gain(dbfm_pkg::CFG_HIGH_GAIN, 16'hffff);
        for (k = 0; k < 7; k++) send_sample(16'h7fff);
        for (k = 6; k >= 0; k--) send_sample(neg_window[k]);
        wait_drained();

        // No idling, both gains zero
        set_gain(dbfm_pkg::CFG_LOW_GAIN, 16'h0000);
        set_gain(dbfm_pkg::CFG_HIGH_GAIN, 16'h0000);
        run_random(PHASE_ITEMS);
        wait_drained();

        // Sender idles, low band only at full gain
        idle_pct = 62;
        set_gain(dbfm_pkg::CFG_LOW_GAIN, 16'hffff);
        run_random(PHASE_ITEMS);
        wait_drained();

        // Receiver stalls, random gains, one long hold-off to back up the input
        idle_pct  = 0;
        stall_pct = 62;
        set_gain(dbfm_pkg::CFG_LOW_GAIN, 16'($urandom));
        set_gain(dbfm_pkg::CFG_HIGH_GAIN, 16'($urandom));
        hold_start = 1'b1;
        run_random(PHASE_ITEMS);
        wait_drained();

        // Both sides idle, high band only at full gain
        idle_pct  = 30;
        stall_pct = 30;
        set_gain(dbfm_pkg::CFG_LOW_GAIN, 16'h0000);
        set_gain(dbfm_pkg::CFG_HIGH_GAIN, 16'hffff);
        run_random(PHASE_ITEMS);
        wait_drained();

        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dbfm_pkg.sv
rtl/dbfm_delay_mem.sv
rtl/dbfm_datapath.sv
rtl/dual_band_fir_mixer.sv
dv/dbfm_mix_checker.sv
dv/tb.sv
